// File: design/rrts_pkg.sv
// rrts_pkg: shared constants, codes and controller/datapath handshake structs
// for the round-robin time slicer; no dependencies
package rrts_pkg;

    // sizing
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int ID_W      = 16;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(4);
    localparam logic [TIME_W-1:0]  TIME_MAX      = '1;

    // request codes, the unused code acts as clear
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SLICE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SLICE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the input item
        logic load;      // store task and append its slot
        logic reject;    // answer a load on a full ring
        logic clear;     // empty ring and zero time
        logic empty;     // answer a slice on an empty ring
        logic rd_slot;   // read the head slot
        logic rd_task;   // read id and remaining time of that slot
        logic slice;     // run the slice and write back
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             ring_empty;
        logic             ring_full;
    } t_stat;

endpackage

// File: design/rrts_ctrl.sv
// rrts_ctrl: sequencing state machine for the time slicer
// depends on rrts_pkg (command and status structs, request codes)
module rrts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rrts_pkg::t_stat i_stat,
    output rrts_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_RD_TASK,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.req)
                    rrts_pkg::REQ_LOAD: begin
                        if (i_stat.ring_full) begin
                            o_cmd.reject = 1'b1;
                        end else begin
                            o_cmd.load = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    rrts_pkg::REQ_SLICE: begin
                        if (i_stat.ring_empty) begin
                            o_cmd.empty = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            o_cmd.rd_slot = 1'b1;
                            n_state       = S_RD_TASK;
                        end
                    end
                    default: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_RD_TASK: begin
                o_cmd.rd_task = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.slice = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // checks
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_DECODE))
        else $error("accepted item did not reach decode");

    a_rd_task_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_TASK) |-> ($past(r_state) == S_DECODE))
        else $error("task read without slot read");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command at once");

endmodule

// File: design/rrts_dp.sv
// rrts_dp: ring queue, task store, clock and result registers
// depends on rrts_pkg (sizes, codes, command and status structs)
module rrts_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrts_pkg::t_cmd                 i_cmd,
    output rrts_pkg::t_stat                o_stat,
    input  logic                           i_cfg_we,
    input  logic [rrts_pkg::BURST_W-1:0]   i_cfg_wdata,
    input  logic [rrts_pkg::REQ_W-1:0]     i_req_type,
    input  logic [rrts_pkg::ID_W-1:0]      i_task_id,
    input  logic [rrts_pkg::BURST_W-1:0]   i_burst_time,
    output logic                           o_valid,
    output logic [rrts_pkg::STATUS_W-1:0]  o_status,
    output logic [rrts_pkg::ID_W-1:0]      o_slice_task_id,
    output logic [rrts_pkg::TIME_W-1:0]    o_slice_start,
    output logic [rrts_pkg::TIME_W-1:0]    o_slice_end,
    output logic                           o_task_completed,
    output logic                           o_queue_now_empty
);

    // memories
    logic [rrts_pkg::IDX_W-1:0]   ring_slots [rrts_pkg::MAX_TASKS];
    logic [rrts_pkg::ID_W-1:0]    task_ids   [rrts_pkg::MAX_TASKS];
    logic [rrts_pkg::BURST_W-1:0] rem_time   [rrts_pkg::MAX_TASKS];

    // control registers
    logic [rrts_pkg::IDX_W-1:0]   r_head;
    logic [rrts_pkg::IDX_W-1:0]   r_tail;
    logic [rrts_pkg::CNT_W-1:0]   r_count;
    logic [rrts_pkg::CNT_W-1:0]   r_loaded;
    logic [rrts_pkg::TIME_W-1:0]  r_time;
    logic [rrts_pkg::BURST_W-1:0] r_quantum;
    logic                         r_valid;

    // latched item and memory read data
    logic [rrts_pkg::REQ_W-1:0]   r_req;
    logic [rrts_pkg::ID_W-1:0]    r_id;
    logic [rrts_pkg::BURST_W-1:0] r_burst;
    logic [rrts_pkg::IDX_W-1:0]   r_slot;
    logic [rrts_pkg::ID_W-1:0]    r_tid;
    logic [rrts_pkg::BURST_W-1:0] r_rem;

    // slice arithmetic
    logic                         requeue;
    logic [rrts_pkg::BURST_W-1:0] run_len;
    logic [rrts_pkg::TIME_W:0]    sum;
    logic [rrts_pkg::TIME_W-1:0]  slice_end;
    logic [rrts_pkg::IDX_W-1:0]   head_inc;
    logic [rrts_pkg::IDX_W-1:0]   tail_inc;
    logic [rrts_pkg::IDX_W-1:0]   load_slot;
    logic [rrts_pkg::CNT_W-1:0]   count_after;

    assign requeue   = (r_rem > r_quantum);
    assign run_len   = requeue ? r_quantum : r_rem;
    assign sum       = {1'b0, r_time} + (rrts_pkg::TIME_W + 1)'(run_len);
    assign slice_end = sum[rrts_pkg::TIME_W] ? rrts_pkg::TIME_MAX
                                             : sum[rrts_pkg::TIME_W-1:0];
    assign load_slot = r_loaded[rrts_pkg::IDX_W-1:0];
    assign count_after = requeue ? r_count : (r_count - rrts_pkg::CNT_W'(1));

    // ring pointer wrap
    assign head_inc = (r_head == rrts_pkg::IDX_W'(rrts_pkg::MAX_TASKS - 1))
                      ? '0 : (r_head + rrts_pkg::IDX_W'(1));
    assign tail_inc = (r_tail == rrts_pkg::IDX_W'(rrts_pkg::MAX_TASKS - 1))
                      ? '0 : (r_tail + rrts_pkg::IDX_W'(1));

    // status to controller
    assign o_stat.req        = r_req;
    assign o_stat.ring_empty = (r_count == '0);
    assign o_stat.ring_full  = (r_count >= rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS)) ||
                               (r_loaded >= rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS));

    // ring slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            ring_slots[r_tail] <= load_slot;
        end else if (i_cmd.slice && requeue) begin
            ring_slots[r_tail] <= r_slot;
        end
        if (i_cmd.rd_slot) begin
            r_slot <= ring_slots[r_head];
        end
    end

    // task id and remaining time memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            task_ids[load_slot] <= r_id;
        end
        if (i_cmd.load) begin
            rem_time[load_slot] <= r_burst;
        end else if (i_cmd.slice) begin
            rem_time[r_slot] <= requeue ? (r_rem - r_quantum) : '0;
        end
        if (i_cmd.rd_task) begin
            r_tid <= task_ids[r_slot];
            r_rem <= rem_time[r_slot];
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= i_req_type;
            r_id    <= i_task_id;
            r_burst <= i_burst_time;
        end
    end

    // ring pointers, counts, clock and quantum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_loaded  <= '0;
            r_time    <= '0;
            r_quantum <= rrts_pkg::QUANTUM_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.load | i_cmd.reject | i_cmd.clear |
                       i_cmd.empty | i_cmd.slice;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_head   <= '0;
                r_tail   <= '0;
                r_count  <= '0;
                r_loaded <= '0;
                r_time   <= '0;
            end else if (i_cmd.load) begin
                r_tail   <= tail_inc;
                r_count  <= r_count + rrts_pkg::CNT_W'(1);
                r_loaded <= r_loaded + rrts_pkg::CNT_W'(1);
            end else if (i_cmd.slice) begin
                r_head  <= head_inc;
                r_time  <= slice_end;
                r_count <= count_after;
                if (requeue) begin
                    r_tail <= tail_inc;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.reject) begin
            o_status          <= i_cmd.load ? rrts_pkg::ST_LOADED : rrts_pkg::ST_REJECT;
            o_slice_task_id   <= r_id;
            o_slice_start     <= '0;
            o_slice_end       <= '0;
            o_task_completed  <= 1'b0;
            o_queue_now_empty <= i_cmd.reject && (r_count == '0);
        end else if (i_cmd.clear || i_cmd.empty) begin
            o_status          <= i_cmd.clear ? rrts_pkg::ST_CLEARED : rrts_pkg::ST_EMPTY;
            o_slice_task_id   <= '0;
            o_slice_start     <= '0;
            o_slice_end       <= '0;
            o_task_completed  <= 1'b0;
            o_queue_now_empty <= 1'b1;
        end else if (i_cmd.slice) begin
            o_status          <= rrts_pkg::ST_SLICE;
            o_slice_task_id   <= r_tid;
            o_slice_start     <= r_time;
            o_slice_end       <= slice_end;
            o_task_completed  <= !requeue;
            o_queue_now_empty <= (count_after == '0);
        end
    end

    assign o_valid = r_valid;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS))
        else $error("ring count above capacity");

    a_count_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_loaded)
        else $error("more slots queued than handed out");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

endmodule

// File: design/round_robin_time_slicer_unit.sv
// round_robin_time_slicer_unit: top level joining controller and datapath
// depends on rrts_pkg, rrts_ctrl, rrts_dp
//
//  channel   ports                                       handshake
//  --------  ------------------------------------------  ----------------------
//  request   i_req_type, i_task_id, i_burst_time         start high, busy low
//  result    o_status, o_slice_task_id, o_slice_start,   o_valid, one cycle
//            o_slice_end, o_task_completed,
//            o_queue_now_empty
//  config    i_cfg_wdata (quantum)                       i_cfg_we
//
// a slice item passes through accept, decode with head slot read, task read and
// execute, as the two registered memory reads lie in series; load, clear and
// empty-ring items pass through accept and decode only. the result strobe follows
// the last step and the next item may be accepted in that same cycle.
// reset clears the ring, counts and clock and sets quantum to 4.
// the result side cannot stall.
module round_robin_time_slicer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rrts_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rrts_pkg::ID_W-1:0]     i_task_id,
    input  logic [rrts_pkg::BURST_W-1:0]  i_burst_time,
    input  logic                          i_cfg_we,
    input  logic [rrts_pkg::BURST_W-1:0]  i_cfg_wdata,
    output logic                          o_valid,
    output logic [rrts_pkg::STATUS_W-1:0] o_status,
    output logic [rrts_pkg::ID_W-1:0]     o_slice_task_id,
    output logic [rrts_pkg::TIME_W-1:0]   o_slice_start,
    output logic [rrts_pkg::TIME_W-1:0]   o_slice_end,
    output logic                          o_task_completed,
    output logic                          o_queue_now_empty
);

    rrts_pkg::t_cmd  cmd;
    rrts_pkg::t_stat stat;

    // sequencer
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // queue, store and result registers
    rrts_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_type        (i_req_type),
        .i_task_id         (i_task_id),
        .i_burst_time      (i_burst_time),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_slice_task_id   (o_slice_task_id),
        .o_slice_start     (o_slice_start),
        .o_slice_end       (o_slice_end),
        .o_task_completed  (o_task_completed),
        .o_queue_now_empty (o_queue_now_empty)
    );

endmodule

// File: tb/round_robin_time_slicer_checker.sv
// round_robin_time_slicer_checker: watches the item, quantum and result
// ports of the time slicer, predicts every result and compares it
// depends on rrts_pkg
module round_robin_time_slicer_checker
    import rrts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [BURST_W-1:0]  i_burst_time,
    input  logic                i_cfg_we,
    input  logic [BURST_W-1:0]  i_cfg_wdata,
    input  logic                i_valid,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [ID_W-1:0]     i_slice_task_id,
    input  logic [TIME_W-1:0]   i_slice_start,
    input  logic [TIME_W-1:0]   i_slice_end,
    input  logic                i_task_completed,
    input  logic                i_queue_now_empty,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id;
        logic [TIME_W-1:0]   t_begin;
        logic [TIME_W-1:0]   t_end;
        logic                completed;
        logic                drained;
    } t_slice_result;

    // scheduler state as predicted from the accepted items
    logic [IDX_W-1:0]   run_order [MAX_TASKS];
    logic [ID_W-1:0]    slot_id   [MAX_TASKS];
    logic [BURST_W-1:0] slot_left [MAX_TASKS];
    logic [IDX_W-1:0]   rd_pos;
    logic [IDX_W-1:0]   wr_pos;
    logic [CNT_W-1:0]   queued;
    logic [CNT_W-1:0]   handed_out;
    logic [TIME_W-1:0]  clock_now;
    logic [BURST_W-1:0] quantum;

    t_slice_result expected_results [$];

    // empty the ring, free every slot and zero the clock
    function automatic void clear_schedule();
        for (int k = 0; k < MAX_TASKS; k++) begin
            run_order[k] = '0;
            slot_id[k]   = '0;
            slot_left[k] = '0;
        end
        rd_pos     = '0;
        wr_pos     = '0;
        queued     = '0;
        handed_out = '0;
        clock_now  = '0;
    endfunction

    // apply one item to the schedule and return the result it causes
    function automatic t_slice_result schedule_step(input logic [REQ_W-1:0] req,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [BURST_W-1:0] burst);
        t_slice_result      r;
        logic [IDX_W-1:0]   slot;
        logic [BURST_W-1:0] left;
        logic [BURST_W-1:0] run;
        logic [TIME_W:0]    sum;
        r = '0;
        case (req)
            REQ_LOAD: begin
                r.task_id = id;
                if (queued >= CNT_W'(MAX_TASKS) || handed_out >= CNT_W'(MAX_TASKS)) begin
                    r.status = ST_REJECT;
                end else begin
                    slot            = handed_out[IDX_W-1:0];
                    slot_id[slot]   = id;
                    slot_left[slot] = burst;
                    handed_out      = handed_out + CNT_W'(1);
                    run_order[wr_pos] = slot;
                    wr_pos          = wr_pos + IDX_W'(1);
                    queued          = queued + CNT_W'(1);
                    r.status        = ST_LOADED;
                end
            end
            REQ_SLICE: begin
                if (queued == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot      = run_order[rd_pos];
                    rd_pos    = rd_pos + IDX_W'(1);
                    queued    = queued - CNT_W'(1);
                    left      = slot_left[slot];
                    r.task_id = slot_id[slot];
                    r.t_begin = clock_now;
                    // longer than a quantum: run one quantum and go to the back
                    if (left > quantum) begin
                        run               = quantum;
                        slot_left[slot]   = left - quantum;
                        run_order[wr_pos] = slot;
                        wr_pos            = wr_pos + IDX_W'(1);
                        queued            = queued + CNT_W'(1);
                    end else begin
                        run             = left;
                        slot_left[slot] = '0;
                        r.completed     = 1'b1;
                    end
                    // clock saturates instead of wrapping
                    sum       = {1'b0, clock_now} + (TIME_W + 1)'(run);
                    r.t_end   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    clock_now = r.t_end;
                    r.status  = ST_SLICE;
                end
            end
            default: begin
                clear_schedule();
                r.status = ST_CLEARED;
            end
        endcase
        r.drained = (queued == '0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                   input logic [TIME_W-1:0] got);
        o_fail_count++;
        if (o_fail_count <= 50)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // compare results, track quantum writes, predict accepted items
    always @(posedge i_clk) begin
        t_slice_result want;
        if (!i_rst_n) begin
            clear_schedule();
            quantum = QUANTUM_RESET;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", '0,
                                    TIME_W'(i_status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", TIME_W'(want.status), TIME_W'(i_status));
                    if (i_slice_task_id !== want.task_id)
                        report_mismatch("slice_task_id", TIME_W'(want.task_id),
                                        TIME_W'(i_slice_task_id));
                    if (i_slice_start !== want.t_begin)
                        report_mismatch("slice_start", want.t_begin, i_slice_start);
                    if (i_slice_end !== want.t_end)
                        report_mismatch("slice_end", want.t_end, i_slice_end);
                    if (i_task_completed !== want.completed)
                        report_mismatch("task_completed", TIME_W'(want.completed),
                                        TIME_W'(i_task_completed));
                    if (i_queue_now_empty !== want.drained)
                        report_mismatch("queue_now_empty", TIME_W'(want.drained),
                                        TIME_W'(i_queue_now_empty));
                end
            end
            if (i_cfg_we)
                quantum = i_cfg_wdata;
            if (i_start && !i_busy)
                expected_results.push_back(schedule_step(i_req_type, i_task_id,
                                                         i_burst_time));
        end
        o_pending = expected_results.size();
    end

endmodule

// File: tb/testbench.sv
// testbench: drives load, slice and clear items into the round-robin time
// slicer across several quantum settings and gives the verdict
// depends on rrts_pkg, round_robin_time_slicer_unit, round_robin_time_slicer_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrts_pkg::*;

    // unused request code, handled as a clear
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type;
    logic [ID_W-1:0]     i_task_id;
    logic [BURST_W-1:0]  i_burst_time;
    logic                i_cfg_we;
    logic [BURST_W-1:0]  i_cfg_wdata;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_slice_task_id;
    logic [TIME_W-1:0]   o_slice_start;
    logic [TIME_W-1:0]   o_slice_end;
    logic                o_task_completed;
    logic                o_queue_now_empty;
    int                  fail_count;
    int                  pending;
    int                  gap_pct;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    round_robin_time_slicer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_task_id         (i_task_id),
        .i_burst_time      (i_burst_time),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_slice_task_id   (o_slice_task_id),
        .o_slice_start     (o_slice_start),
        .o_slice_end       (o_slice_end),
        .o_task_completed  (o_task_completed),
        .o_queue_now_empty (o_queue_now_empty)
    );

    round_robin_time_slicer_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_req_type        (i_req_type),
        .i_task_id         (i_task_id),
        .i_burst_time      (i_burst_time),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (o_valid),
        .i_status          (o_status),
        .i_slice_task_id   (o_slice_task_id),
        .i_slice_start     (o_slice_start),
        .i_slice_end       (o_slice_end),
        .i_task_completed  (o_task_completed),
        .i_queue_now_empty (o_queue_now_empty),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // offer one item after a random gap, return at the falling edge after acceptance
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] burst);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            start        <= 1'b0;
            i_req_type   <= REQ_W'($urandom);
            i_task_id    <= ID_W'($urandom);
            i_burst_time <= BURST_W'($urandom);
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_task_id    <= id;
        i_burst_time <= burst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_quantum(input logic [BURST_W-1:0] q);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= q;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // bursts mostly a few quanta long, with the extremes mixed in
    function automatic logic [BURST_W-1:0] pick_burst(input int q);
        int span;
        span = 3 * q + 2;
        if (span > 65535)
            span = 65535;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return BURST_W'($urandom);
            default: return BURST_W'($urandom_range(span));
        endcase
    endfunction

    // alternate load-heavy and drain-heavy stretches, with rare clears
    task automatic run_random(input int count, input int q);
        bit               load_heavy;
        int               roll;
        logic [REQ_W-1:0] req;
        load_heavy = 1'b1;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 8)
                load_heavy = !load_heavy;
            roll = $urandom_range(99);
            if (roll < 2)
                req = ($urandom_range(1) != 0) ? REQ_CLEAR : REQ_RESERVED;
            else if (roll < (load_heavy ? 70 : 22))
                req = REQ_LOAD;
            else
                req = REQ_SLICE;
            send_item(req, ID_W'($urandom), pick_burst(q));
        end
    endtask

    // stimulus and verdict
    initial begin
        int                 waited;
        logic [BURST_W-1:0] q;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= REQ_LOAD;
        i_task_id    <= '0;
        i_burst_time <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        gap_pct       = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, reserved code, zero and full bursts, exact quantum
        send_item(REQ_SLICE, 16'h5A5A, 16'h0003);
        send_item(REQ_RESERVED, 16'hFFFF, 16'hFFFF);
        send_item(REQ_LOAD, 16'h0000, 16'h0000);
        send_item(REQ_LOAD, 16'hFFFF, 16'hFFFF);
        send_item(REQ_LOAD, 16'h1234, QUANTUM_RESET);
        send_item(REQ_LOAD, 16'h00A5, QUANTUM_RESET + BURST_W'(1));
        repeat (6) send_item(REQ_SLICE, 16'h0000, 16'h0000);
        send_item(REQ_CLEAR, 16'h0000, 16'h0000);
        send_item(REQ_SLICE, 16'hFFFF, 16'hFFFF);

        // random phases over several quantum settings and idle rates
        write_quantum(16'd1);
        gap_pct = 0;
        run_random(150, 1);

        write_quantum(16'hFFFF);
        gap_pct = 80;
        run_random(150, 65535);

        write_quantum(16'd0);
        gap_pct = 24;
        run_random(100, 0);

        q = BURST_W'($urandom_range(2, 12));
        write_quantum(q);
        gap_pct = 0;
        run_random(150, q);

        q = BURST_W'($urandom_range(13, 65534));
        write_quantum(q);
        gap_pct = 80;
        run_random(150, q);

        // midway the sender stops until the block has answered everything
        write_quantum(16'd5);
        gap_pct = 24;
        run_random(120, 5);
        wait_drained();
        run_random(120, 5);

        // drain and settle
        start  <= 1'b0;
        waited  = 0;
        while (pending != 0 && waited < 1000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
